### sv/bdras_pkg.sv
// Shared types and codes for the block-decomposed range add/sum store.
// No dependencies.
package bdras_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_SUM   = 2'd2;

  // One entry of the block memory.
  typedef struct packed {
    logic [63:0] total;
    logic [63:0] pend;
  } blk_t;

endpackage

### sv/bdras_ram.sv
// Single-port-write, single-port-read synchronous RAM, registered read data.
// No dependencies.
module bdras_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bdras_ctrl.sv
// Sequencer: decodes a transaction, walks element and block memories with
// read-modify-write streams, and holds the result register. Uses bdras_pkg.
module bdras_ctrl
  import bdras_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int BLOCK_LEN    = 32,
  parameter int AW           = 10,
  parameter int BW           = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [9:0]          index_low,
  input  logic [9:0]          index_high,
  input  logic signed [63:0]  operand_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  range_sum,
  output logic                status,
  output logic                e_we,
  output logic [AW-1:0]       e_waddr,
  output logic [63:0]         e_wdata,
  output logic [AW-1:0]       e_raddr,
  input  logic [63:0]         e_rdata,
  output logic                b_we,
  output logic [BW-1:0]       b_waddr,
  output blk_t                b_wdata,
  output logic [BW-1:0]       b_raddr,
  input  blk_t                b_rdata
);

  localparam int BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam logic [31:0] RECIP = 32'(((1 << 20) + BLOCK_LEN - 1) / BLOCK_LEN);
  localparam logic [31:0] MAX_W = 32'(MAX_ELEMENTS);
  localparam logic [31:0] BS_W  = 32'(BLOCK_LEN);
  localparam logic [31:0] BC_W  = 32'(BLOCK_COUNT);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_PBRD  = 4'd4;
  localparam logic [3:0] S_PBGET = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_PBWR  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  localparam logic [1:0] M_PUSH = 2'd0;
  localparam logic [1:0] M_SPAN = 2'd1;
  localparam logic [1:0] M_MID  = 2'd2;

  logic [3:0]    state;
  logic [1:0]    mode;
  logic [10:0]   used_length;
  logic [1:0]    act;
  logic [9:0]    lo_r;
  logic [9:0]    hi_r;
  logic [63:0]   x_r;
  logic [63:0]   xbs;
  logic          bad;
  logic          last;
  logic [BW-1:0] sb;
  logic [BW-1:0] eb;
  logic [BW-1:0] cur_b;
  logic [AW-1:0] span_lo;
  logic [AW-1:0] span_hi;
  logic [AW-1:0] ptr;
  logic [AW-1:0] wend;
  logic          issuing;
  logic          d_valid;
  logic [AW-1:0] d_addr;
  logic [63:0]   tot;
  logic [63:0]   pend;
  logic [63:0]   sum;

  logic [31:0] len_eff;
  logic [31:0] lo_prod;
  logic [31:0] hi_prod;
  logic [31:0] blk_first;
  logic [31:0] blk_stop;
  logic [31:0] sb_next_first;
  logic [31:0] eb_first;
  logic        bad_next;

  always_comb begin
    len_eff       = (32'(used_length) > MAX_W) ? MAX_W : 32'(used_length);
    lo_prod       = 32'(lo_r) * RECIP;
    hi_prod       = 32'(hi_r) * RECIP;
    blk_first     = 32'(cur_b) * BS_W;
    blk_stop      = blk_first + BS_W;
    if (blk_stop > MAX_W) begin
      blk_stop = MAX_W;
    end
    sb_next_first = (32'(sb) + 32'd1) * BS_W;
    eb_first      = 32'(eb) * BS_W;
    case (act)
      ACT_WRITE: bad_next = 32'(lo_r) >= len_eff;
      ACT_ADD, ACT_SUM: bad_next = (lo_r > hi_r) || (32'(hi_r) >= len_eff);
      default: bad_next = 1'b1;
    endcase
  end

  // Memory port drive
  always_comb begin
    e_raddr = ptr;
    e_we    = 1'b0;
    e_waddr = d_addr;
    e_wdata = '0;
    b_raddr = cur_b;
    b_we    = 1'b0;
    b_waddr = cur_b;
    b_wdata = '{total: tot, pend: pend};
    case (state)
      S_CLR: begin
        e_we    = 1'b1;
        e_waddr = ptr;
        b_we    = 32'(ptr) < BC_W;
        b_waddr = BW'(ptr);
        b_wdata = '0;
      end
      S_PBWR: begin
        b_we = 1'b1;
      end
      S_WALK: begin
        b_raddr = BW'(ptr);
        b_waddr = BW'(d_addr);
        b_wdata = '{total: b_rdata.total + xbs, pend: b_rdata.pend + x_r};
        case (mode)
          M_PUSH: begin
            e_we    = d_valid;
            e_wdata = e_rdata + pend;
          end
          M_SPAN: begin
            e_we    = d_valid && (act != ACT_SUM);
            e_wdata = (act == ACT_WRITE) ? x_r : e_rdata + x_r;
          end
          M_MID: begin
            b_we = d_valid && (act == ACT_ADD);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      ptr         <= '0;
      issuing     <= 1'b0;
      d_valid     <= 1'b0;
      out_valid   <= 1'b0;
      used_length <= 11'd1024;
    end else begin
      if (cfg_we) begin
        used_length <= cfg_wdata;
      end
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          ptr <= ptr + 1'b1;
          if (32'(ptr) == MAX_W - 32'd1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            act   <= action;
            lo_r  <= index_low;
            hi_r  <= index_high;
            x_r   <= operand_value;
            sum   <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          bad   <= bad_next;
          sb    <= BW'(lo_prod >> 20);
          eb    <= BW'(hi_prod >> 20);
          xbs   <= x_r * 64'(BLOCK_LEN);
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          cur_b   <= sb;
          span_lo <= AW'(lo_r);
          if (bad) begin
            state <= S_FIN;
          end else begin
            state <= S_PBRD;
            if (act == ACT_WRITE) begin
              span_hi <= AW'(lo_r);
              last    <= 1'b1;
            end else if (sb == eb) begin
              span_hi <= AW'(hi_r);
              last    <= 1'b1;
            end else begin
              span_hi <= AW'(sb_next_first - 32'd1);
              last    <= 1'b0;
            end
          end
        end
        S_PBRD: begin
          state <= S_PBGET;
        end
        S_PBGET: begin
          tot     <= b_rdata.total;
          pend    <= b_rdata.pend;
          issuing <= 1'b1;
          state   <= S_WALK;
          if (b_rdata.pend != '0) begin
            mode <= M_PUSH;
            ptr  <= AW'(blk_first);
            wend <= AW'(blk_stop - 32'd1);
          end else begin
            mode <= M_SPAN;
            ptr  <= span_lo;
            wend <= span_hi;
          end
        end
        S_WALK: begin
          if (issuing) begin
            ptr <= ptr + 1'b1;
            if (ptr == wend) begin
              issuing <= 1'b0;
            end
          end
          d_valid <= issuing;
          d_addr  <= ptr;
          if (d_valid) begin
            if (mode == M_SPAN) begin
              case (act)
                ACT_WRITE: tot <= tot + x_r - e_rdata;
                ACT_ADD:   tot <= tot + x_r;
                default:   sum <= sum + e_rdata;
              endcase
            end else if (mode == M_MID && act == ACT_SUM) begin
              sum <= sum + b_rdata.total;
            end
          end
          if (!issuing && !d_valid) begin
            case (mode)
              M_PUSH: begin
                pend    <= '0;
                mode    <= M_SPAN;
                ptr     <= span_lo;
                wend    <= span_hi;
                issuing <= 1'b1;
              end
              M_SPAN: begin
                state <= S_PBWR;
              end
              default: begin
                cur_b   <= eb;
                span_lo <= AW'(eb_first);
                span_hi <= AW'(hi_r);
                last    <= 1'b1;
                state   <= S_PBRD;
              end
            endcase
          end
        end
        S_PBWR: begin
          if (last) begin
            state <= S_FIN;
          end else if (32'(eb) > 32'(sb) + 32'd1) begin
            mode    <= M_MID;
            ptr     <= AW'(sb) + 1'b1;
            wend    <= AW'(eb) - 1'b1;
            issuing <= 1'b1;
            state   <= S_WALK;
          end else begin
            cur_b   <= eb;
            span_lo <= AW'(eb_first);
            span_hi <= AW'(hi_r);
            last    <= 1'b1;
            state   <= S_PBRD;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            range_sum <= bad ? '0 : sum;
            status    <= bad;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/block_decomposed_range_add_sum.sv
// Top level: element and block memories around the sequencer.
// Depends on bdras_pkg, bdras_ram, bdras_ctrl.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   in       | in_valid / in_ready  | action, index_low, index_high, operand_value
//   out      | out_valid / out_ready| range_sum, status
//   cfg      | cfg_we               | cfg_wdata (used_length)
//
// One transaction at a time. A transaction checks the range, then for each partial block
// reads its block entry, pushes any pending add down over the whole block, walks the
// span and writes the block entry back; a bad range goes straight to the result.
// Whole blocks between the two partial blocks stream at one per cycle.
// The element memory's one read and one write per cycle paces the element walks.
// After rst a clearing pass zeroes the element and block memories with in_ready low.
// A finished result waits in the output register while the next one is taken;
// the next result holds until that one is accepted.
module block_decomposed_range_add_sum
  import bdras_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  parameter int BLOCK_LEN    = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [9:0]         index_low,
  input  logic [9:0]         index_high,
  input  logic signed [63:0] operand_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] range_sum,
  output logic               status
);

  localparam int BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

  logic          e_we;
  logic [AW-1:0] e_waddr;
  logic [63:0]   e_wdata;
  logic [AW-1:0] e_raddr;
  logic [63:0]   e_rdata;
  logic          b_we;
  logic [BW-1:0] b_waddr;
  blk_t          b_wdata;
  logic [BW-1:0] b_raddr;
  blk_t          b_rdata;

  bdras_ram #(.WIDTH(64), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_elem (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  bdras_ram #(.WIDTH($bits(blk_t)), .DEPTH(BLOCK_COUNT), .AW(BW)) u_blk (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  bdras_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .BLOCK_LEN    (BLOCK_LEN),
    .AW           (AW),
    .BW           (BW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .index_low     (index_low),
    .index_high    (index_high),
    .operand_value (operand_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .range_sum     (range_sum),
    .status        (status),
    .e_we          (e_we),
    .e_waddr       (e_waddr),
    .e_wdata       (e_wdata),
    .e_raddr       (e_raddr),
    .e_rdata       (e_rdata),
    .b_we          (b_we),
    .b_waddr       (b_waddr),
    .b_wdata       (b_wdata),
    .b_raddr       (b_raddr),
    .b_rdata       (b_rdata)
  );

endmodule

### tb/sv/block_decomposed_range_add_sum_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for block_decomposed_range_add_sum: random and directed
// element writes, range adds and range sums checked against a behavioral model.
// Depends on bdras_pkg and the block_decomposed_range_add_sum RTL.
module block_decomposed_range_add_sum_tb
  import bdras_pkg::*;
();

  localparam int NUM_ELEM  = 1024;
  localparam int BLK       = 32;
  localparam int NUM_BLK   = NUM_ELEM / BLK;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] ACT_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]  act;
    logic [9:0]  lo;
    logic [9:0]  hi;
    logic [63:0] val;
  } op_t;

  typedef struct packed {
    logic [63:0] total;
    logic        err;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = '0;
  logic [9:0] index_low = '0;
  logic [9:0] index_high = '0;
  logic signed [63:0] operand_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] range_sum;
  logic status;

  block_decomposed_range_add_sum DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .index_low(index_low), .index_high(index_high), .operand_value(operand_value),
    .out_valid(out_valid), .out_ready(out_ready), .range_sum(range_sum),
    .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic [63:0] elem_m [NUM_ELEM];
  logic [63:0] btot_m [NUM_BLK];
  logic [63:0] bpend_m [NUM_BLK];
  logic        bflag_m [NUM_BLK];
  logic [10:0] len_reg;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   mismatches = 0;
  int   checked = 0;
  int   err_count = 0;
  int   idle_cycles = 0;

  task automatic push_down(input int b);
    if (bflag_m[b]) begin
      for (int i = b * BLK; i < (b + 1) * BLK; i++) elem_m[i] += bpend_m[b];
      bpend_m[b] = '0;
      bflag_m[b] = 1'b0;
    end
  endtask

  task automatic span_add(input int lo, input int hi, input logic [63:0] x);
    int b;
    b = lo / BLK;
    push_down(b);
    for (int i = lo; i <= hi; i++) begin
      elem_m[i] += x;
      btot_m[b] += x;
    end
  endtask

  task automatic span_total(input int lo, input int hi, inout logic [63:0] s);
    push_down(lo / BLK);
    for (int i = lo; i <= hi; i++) s += elem_m[i];
  endtask

  task automatic apply_op(input op_t op, output res_t r);
    int len, lo, hi, sb, eb;
    lo = int'(op.lo);
    hi = int'(op.hi);
    len = (len_reg > NUM_ELEM) ? NUM_ELEM : int'(len_reg);
    r = '0;
    case (op.act)
      ACT_WRITE: begin
        if (lo >= len) r.err = 1'b1;
        else begin
          push_down(lo / BLK);
          btot_m[lo / BLK] += op.val - elem_m[lo];
          elem_m[lo] = op.val;
        end
      end
      ACT_ADD, ACT_SUM: begin
        if (lo > hi || hi >= len) r.err = 1'b1;
        else begin
          sb = lo / BLK;
          eb = hi / BLK;
          if (sb == eb) begin
            if (op.act == ACT_ADD) span_add(lo, hi, op.val);
            else span_total(lo, hi, r.total);
          end else if (op.act == ACT_ADD) begin
            span_add(lo, (sb + 1) * BLK - 1, op.val);
            for (int b = sb + 1; b < eb; b++) begin
              bpend_m[b] += op.val;
              bflag_m[b] = 1'b1;
              btot_m[b] += op.val * BLK;
            end
            span_add(eb * BLK, hi, op.val);
          end else begin
            span_total(lo, (sb + 1) * BLK - 1, r.total);
            for (int b = sb + 1; b < eb; b++) r.total += btot_m[b];
            span_total(eb * BLK, hi, r.total);
          end
        end
      end
      default: r.err = 1'b1;
    endcase
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatches++;
    $display("MISMATCH %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op_t op;
        res_t r;
        op = pending_ops.pop_front();
        apply_op(op, r);
        expected_results.push_back(r);
        action <= op.act;
        index_low <= op.lo;
        index_high <= op.hi;
        operand_value <= op.val;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 97) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 2) != 0);
        default: out_ready <= ((stall_phase % 23) < 15);
      endcase
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", range_sum, '0);
        end else begin
          res_t e;
          e = expected_results.pop_front();
          checked++;
          if (e.err) err_count++;
          if (range_sum !== e.total) report("range_sum", range_sum, e.total);
          if (status !== e.err) report("status", 64'(status), 64'(e.err));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TIMEOUT: no transaction for %0d cycles", IDLE_LIMIT);
        $display("block_decomposed_range_add_sum verification failed");
        $finish;
      end
    end
  end

  function automatic op_t mk(input logic [1:0] a, input int lo, input int hi,
                             input logic [63:0] v);
    op_t o;
    o.act = a;
    o.lo = 10'(lo);
    o.hi = 10'(hi);
    o.val = v;
    return o;
  endfunction

  function automatic op_t rand_op(input int len);
    op_t o;
    int lo, hi, k;
    k = $urandom_range(0, 99);
    lo = $urandom_range(0, len - 1);
    hi = $urandom_range(lo, len - 1);
    if ($urandom_range(0, 3) == 0) hi = $urandom_range(lo, (lo + 40 < len) ? lo + 40 : len - 1);
    o.val = {$urandom, $urandom};
    if ($urandom_range(0, 2) == 0) o.val = 64'($signed($urandom_range(0, 2000)) - 1000);
    if (k < 25) o.act = ACT_WRITE;
    else if (k < 55) o.act = ACT_ADD;
    else if (k < 92) o.act = ACT_SUM;
    else begin
      o.act = 2'($urandom_range(0, 3));
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
    end
    o.lo = 10'(lo);
    o.hi = 10'(hi);
    return o;
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_length(input logic [10:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_reg = v;
  endtask

  initial begin
    logic [10:0] lens [6];
    for (int i = 0; i < NUM_ELEM; i++) elem_m[i] = '0;
    for (int b = 0; b < NUM_BLK; b++) begin
      btot_m[b] = '0;
      bpend_m[b] = '0;
      bflag_m[b] = 1'b0;
    end
    len_reg = 11'd1024;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    pending_ops.push_back(mk(ACT_SUM, 0, 1023, '0));
    pending_ops.push_back(mk(ACT_WRITE, 0, 0, 64'h7fff_ffff_ffff_ffff));
    pending_ops.push_back(mk(ACT_WRITE, 1023, 0, 64'h8000_0000_0000_0000));
    pending_ops.push_back(mk(ACT_WRITE, 517, 3, 64'hffff_ffff_ffff_ffff));
    pending_ops.push_back(mk(ACT_ADD, 3, 900, 64'h5555_aaaa_5555_aaaa));
    pending_ops.push_back(mk(ACT_ADD, 0, 1023, 64'h8000_0000_0000_0001));
    pending_ops.push_back(mk(ACT_ADD, 40, 45, 64'd7));
    pending_ops.push_back(mk(ACT_SUM, 64, 95, '0));
    pending_ops.push_back(mk(ACT_WRITE, 100, 0, 64'd5));
    pending_ops.push_back(mk(ACT_SUM, 0, 1023, '0));
    pending_ops.push_back(mk(ACT_SUM, 31, 32, '0));
    pending_ops.push_back(mk(ACT_SUM, 10, 9, '0));
    pending_ops.push_back(mk(ACT_ADD, 500, 499, 64'd1));
    pending_ops.push_back(mk(ACT_BAD, 0, 1023, 64'd3));
    pending_ops.push_back(mk(ACT_SUM, 1023, 1023, '0));
    drain();
    set_length(11'd1);
    pending_ops.push_back(mk(ACT_WRITE, 1, 0, 64'd9));
    pending_ops.push_back(mk(ACT_SUM, 0, 1, '0));
    pending_ops.push_back(mk(ACT_SUM, 0, 0, '0));
    drain();
    set_length(11'd0);
    pending_ops.push_back(mk(ACT_WRITE, 0, 0, 64'd9));
    pending_ops.push_back(mk(ACT_SUM, 0, 0, '0));
    drain();
    set_length(11'h7ff);
    pending_ops.push_back(mk(ACT_SUM, 0, 1023, '0));
    drain();

    lens = '{11'd1024, 11'd70, 11'd2047, 11'd1, 11'd513, 11'd1024};
    for (int p = 0; p < 6; p++) begin
      int len;
      set_length(lens[p]);
      len = (lens[p] > NUM_ELEM) ? NUM_ELEM : int'(lens[p]);
      for (int n = 0; n < 290; n++) pending_ops.push_back(rand_op(len));
      drain();
    end

    $display("Checked %0d results (%0d error status) over %0d length settings.",
             checked, err_count, 10);
    if (mismatches == 0) begin
      $display("block_decomposed_range_add_sum verification clean");
    end else begin
      $display("block_decomposed_range_add_sum verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/bdras_pkg.sv
sv/bdras_ram.sv
sv/bdras_ctrl.sv
sv/block_decomposed_range_add_sum.sv
tb/sv/block_decomposed_range_add_sum_tb.sv
